/* design/lzdmc_pkg.sv */
// shared types and constants of the lz dictionary match coverage block
package lzdmc_pkg;

  // field widths
  localparam int LEN_BITS    = 17;
  localparam int OFF_BITS    = 22;
  localparam int IDX_BITS    = 14;
  localparam int CFG_BITS    = 15;
  localparam int POS_BITS    = 32;
  localparam int TOTAL_BITS  = 48;
  localparam int OUT_CNT_BITS = 32;

  // packed bus widths
  localparam int S_DATA_BITS = 72;
  localparam int M_DATA_BITS = 104;

  // configuration port
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CONTENT_SIZE = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BUCKET_SIZE  = 1'd1;
  localparam logic [CFG_BITS-1:0] CONTENT_SIZE_RST = 15'd16384;
  localparam logic [CFG_BITS-1:0] BUCKET_SIZE_RST  = 15'd1;

  // request kind carried on tuser
  localparam logic MODE_PROCESS = 1'b0;
  localparam logic MODE_READ    = 1'b1;

  // divider steps, one quotient bit per cycle
  localparam int DIV_BITS      = 15;
  localparam int DIV_STEP_BITS = 4;

  typedef struct packed {
    logic                done;
    logic [DIV_BITS-1:0] quotient;
    logic [DIV_BITS-1:0] remainder;
  } div_res_t;

endpackage

/* design/lzdmc_divider.sv */
// iterative restoring divider, one quotient bit per cycle
module lzdmc_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lzdmc_pkg::DIV_BITS-1:0] dividend,
  input  logic [lzdmc_pkg::DIV_BITS-1:0] divisor,
  output lzdmc_pkg::div_res_t            res
);

  localparam int W = lzdmc_pkg::DIV_BITS;

  logic                                  busy;
  logic                                  done;
  logic [lzdmc_pkg::DIV_STEP_BITS-1:0]   step;
  logic [W-1:0]                          quo;
  logic [W-1:0]                          rem;
  logic [W-1:0]                          dvs;
  logic [W:0]                            rem_sh;
  logic [W:0]                            diff;
  logic                                  ge;

  always_comb begin
    rem_sh = {rem, quo[W-1]};
    ge     = rem_sh >= {1'b0, dvs};
    diff   = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == lzdmc_pkg::DIV_STEP_BITS'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[W-1:0] : rem_sh[W-1:0];
      quo <= {quo[W-2:0], ge};
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

/* design/lzdmc_hist_ram.sv */
// histogram memory, one write and one registered read port
module lzdmc_hist_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/lz_dictionary_match_coverage.sv */
// top level: lz match coverage sequencer, histogram and result register
//
// Takes one request at a time. A process request (tuser low) tracks the
// position inside the current sample; when its match reaches back before
// the sample start, every reached byte of the dictionary content region
// (clipped to the sample start and to content_size, itself capped at
// MAX_CONTENT) adds one to histogram bucket pos / bucket_size and to the
// 48-bit running total, both saturating. A read request (tuser high)
// returns one bucket count. Sequence, from the idle cycle that takes a
// request to the idle cycle that can take the next, with the output
// register free: a read request passes the RDM, RDQ and finish states.
// A process request whose match does not reach back passes CALC_A and
// finish, one that reaches back but counts no byte also CALC_B and
// CALC_C, and one with counted bytes runs the idle cycle, the setup
// states CALC_A, CALC_B and CALC_C, the bit-serial divider (15 quotient
// bits and a hand-over of the first byte's bucket and offset), one
// histogram read and one write per byte on the single-port-per-direction
// memory (later bytes step the bucket by increment, no further division),
// and the finish cycle that loads the result register. The result is valid
// from the cycle after the finish cycle and sits in an output register, so
// a new request is taken while the previous result waits. After reset a
// clearing pass zeroes the histogram, taking no request; configuration
// writes are accepted at any time the block is idle.
module lz_dictionary_match_coverage #(
  parameter int MAX_CONTENT = 16384,
  parameter int COUNT_BITS  = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // request: new_sample, literal_length, match_length, match_offset,
  // bucket_index from the lowest bit up, one zero pad bit
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [lzdmc_pkg::S_DATA_BITS-1:0]     s_tdata,
  // request kind: mode
  input  logic                                  s_tuser,
  // result: hit_bytes, bucket_count, running_total from the lowest
  // bit up, zero padded
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [lzdmc_pkg::M_DATA_BITS-1:0]     m_tdata,
  // configuration write port
  input  logic                                  cfg_we,
  input  logic [lzdmc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [lzdmc_pkg::CFG_BITS-1:0]        cfg_data
);

  localparam int AW = (MAX_CONTENT > 1) ? $clog2(MAX_CONTENT) : 1;
  localparam logic [31:0] MAXC32 = 32'(MAX_CONTENT);

  localparam int LB = lzdmc_pkg::LEN_BITS;
  localparam int OB = lzdmc_pkg::OFF_BITS;
  localparam int CB = lzdmc_pkg::CFG_BITS;
  localparam int PB = lzdmc_pkg::POS_BITS;
  localparam int TB = lzdmc_pkg::TOTAL_BITS;
  localparam int QB = lzdmc_pkg::DIV_BITS;

  // sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CALC_A = 4'd2;
  localparam logic [3:0] S_CALC_B = 4'd3;
  localparam logic [3:0] S_CALC_C = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_RD     = 4'd6;
  localparam logic [3:0] S_WR     = 4'd7;
  localparam logic [3:0] S_RDM    = 4'd8;
  localparam logic [3:0] S_RDQ    = 4'd9;
  localparam logic [3:0] S_FINISH = 4'd10;

  logic [3:0]    state;

  // configuration
  logic [CB-1:0] content_size;
  logic [CB-1:0] bucket_size;
  logic [CB-1:0] csize_eff;
  logic [CB-1:0] bsize_eff;

  // architectural state
  logic [PB-1:0] sample_pos;
  logic [TB-1:0] total;
  logic [AW-1:0] clr_addr;

  // captured request
  logic          mode_r;
  logic [LB-1:0] ll_r;
  logic [LB-1:0] ml_r;
  logic [OB-1:0] off_r;
  logic [lzdmc_pkg::IDX_BITS-1:0] idx_r;

  // per-request working registers
  logic [OB-1:0] neg;        // distance of match start before sample start
  logic [LB-1:0] run;
  logic [23:0]   first_s;    // signed content position of first byte
  logic [LB-1:0] hits;
  logic [LB-1:0] left;
  logic [QB-1:0] bkt;
  logic [QB-1:0] bkt_rem;
  logic [lzdmc_pkg::OUT_CNT_BITS-1:0] count_r;

  // datapath wires
  logic [PB:0]   sum_a;
  logic          hit_a;
  logic [23:0]   last_s;
  logic [23:0]   first_c;
  logic [23:0]   span;
  logic          span_pos;
  logic [LB-1:0] cnt_c;
  logic [QB-1:0] rem_inc;
  logic [PB+1:0] pos_next;
  logic [31:0]   bkt_ext;
  logic [31:0]   idx_ext;
  logic          idx_ok;

  // divider
  logic                div_start;
  lzdmc_pkg::div_res_t div_res;

  // histogram port
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] ram_inc;
  logic [lzdmc_pkg::OUT_CNT_BITS-1:0] cnt_sat;

  // output register
  logic          out_load;
  logic [LB-1:0] out_hits;
  logic [lzdmc_pkg::OUT_CNT_BITS-1:0] out_count;
  logic [TB-1:0] out_total;

  assign csize_eff = (32'(content_size) > MAXC32) ? MAXC32[CB-1:0] : content_size;
  assign bsize_eff = (bucket_size == '0) ? CB'(1) : bucket_size;

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_FINISH) && (!m_tvalid || m_tready);

  // match start relative to sample start, negative means it reaches back
  always_comb begin
    sum_a = {1'b0, sample_pos} + (PB+1)'(ll_r);
    hit_a = (ml_r != '0) && ((PB+1)'(off_r) > sum_a);
  end

  // clip run to the content region and the sample start
  always_comb begin
    last_s   = first_s + 24'(run);
    first_c  = first_s[23] ? 24'd0 : first_s;
    span     = last_s - first_c;
    span_pos = $signed(last_s) > $signed(first_c);
    cnt_c    = span_pos ? span[LB-1:0] : '0;
  end

  assign div_start = (state == S_CALC_C) && (cnt_c != '0);
  assign rem_inc   = bkt_rem + 1'b1;
  assign pos_next  = (PB+2)'(sample_pos) + (PB+2)'(ll_r) + (PB+2)'(ml_r);

  assign bkt_ext = 32'(bkt);
  assign idx_ext = 32'(idx_r);
  assign idx_ok  = idx_ext < MAXC32;

  assign ram_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;

  generate
    if (COUNT_BITS > lzdmc_pkg::OUT_CNT_BITS) begin : g_wide_cnt
      assign cnt_sat = (|ram_rdata[COUNT_BITS-1:lzdmc_pkg::OUT_CNT_BITS]) ? '1
                     : ram_rdata[lzdmc_pkg::OUT_CNT_BITS-1:0];
    end else begin : g_narrow_cnt
      assign cnt_sat = lzdmc_pkg::OUT_CNT_BITS'(ram_rdata);
    end
  endgenerate

  // memory port steering: clearing pass, or per-byte increment
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bkt_ext[AW-1:0];
    ram_wdata = ram_inc;
    ram_raddr = bkt_ext[AW-1:0];
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_WR: begin
        ram_we = 1'b1;
      end
      S_RDM: begin
        ram_raddr = idx_ext[AW-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lzdmc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (first_c[QB-1:0]),
    .divisor  (bsize_eff),
    .res      (div_res)
  );

  lzdmc_hist_ram #(
    .DEPTH (MAX_CONTENT),
    .AW    (AW),
    .DW    (COUNT_BITS)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      content_size <= lzdmc_pkg::CONTENT_SIZE_RST;
      bucket_size  <= lzdmc_pkg::BUCKET_SIZE_RST;
      sample_pos   <= '0;
      total        <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lzdmc_pkg::CFG_CONTENT_SIZE: content_size <= cfg_data;
          lzdmc_pkg::CFG_BUCKET_SIZE:  bucket_size  <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(MAX_CONTENT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser == lzdmc_pkg::MODE_READ) begin
              state <= S_RDM;
            end else begin
              state <= S_CALC_A;
              if (s_tdata[0]) begin
                sample_pos <= '0;
              end
            end
          end
        end
        S_CALC_A: begin
          state <= hit_a ? S_CALC_B : S_FINISH;
        end
        S_CALC_B: begin
          state <= S_CALC_C;
        end
        S_CALC_C: begin
          state <= (cnt_c != '0) ? S_DIV : S_FINISH;
        end
        S_DIV: begin
          if (div_res.done) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (total != '1) begin
            total <= total + 1'b1;
          end
          state <= (left == LB'(1)) ? S_FINISH : S_RD;
        end
        S_RDM: begin
          state <= S_RDQ;
        end
        S_RDQ: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_load) begin
            state <= S_IDLE;
            if (mode_r == lzdmc_pkg::MODE_PROCESS) begin
              sample_pos <= (|pos_next[PB+1:PB]) ? '1 : pos_next[PB-1:0];
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request payload and working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        mode_r  <= s_tuser;
        ll_r    <= s_tdata[17:1];
        ml_r    <= s_tdata[34:18];
        off_r   <= s_tdata[56:35];
        idx_r   <= s_tdata[70:57];
        hits    <= '0;
        count_r <= '0;
      end
      S_CALC_A: begin
        neg <= off_r - sum_a[OB-1:0];
      end
      S_CALC_B: begin
        run     <= (OB'(ml_r) < neg) ? ml_r : neg[LB-1:0];
        first_s <= 24'(csize_eff) - 24'(neg);
      end
      S_CALC_C: begin
        hits <= cnt_c;
        left <= cnt_c;
      end
      S_DIV: begin
        bkt     <= div_res.quotient;
        bkt_rem <= div_res.remainder;
      end
      S_WR: begin
        left <= left - 1'b1;
        // step to the next content byte, bucket advances on wrap
        if (rem_inc == bsize_eff) begin
          bkt_rem <= '0;
          bkt     <= bkt + 1'b1;
        end else begin
          bkt_rem <= rem_inc;
        end
      end
      S_RDQ: begin
        count_r <= idx_ok ? cnt_sat : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hits  <= hits;
      out_count <= count_r;
      out_total <= total;
    end
  end

  assign m_tdata = {7'd0, out_total, out_count, out_hits};

  // byte loop only runs with work left
  assert property (@(posedge clk) disable iff (rst)
    state == S_WR |-> left != '0)
    else $error("byte loop entered with no bytes left");

  // every counted byte maps to a bucket inside the histogram
  assert property (@(posedge clk) disable iff (rst)
    state == S_WR |-> bkt_ext < MAXC32)
    else $error("bucket address beyond histogram depth");

  // counted bytes never exceed the match length
  assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH |-> hits <= ml_r)
    else $error("more bytes counted than the match holds");

  // the running total never goes down
  assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> total >= $past(total))
    else $error("running total decreased");

endmodule
